FILE: design/ocpt_pkg.sv
// ----------------------------------------------------------------------------
// ocpt_pkg: shared constants, types and functions of the orbit camera
// point transform (widths, register map, trig tables).
// ----------------------------------------------------------------------------
package ocpt_pkg;

  // Field widths
  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int ANG_W      = 9;
  localparam int RAD_W      = 20;
  localparam int ZOOM_W     = 10;
  localparam int OUT_W      = 32;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  // Internal widths
  localparam int TRIG_W = FRAC_BITS + 2;           // signed Q2.FRAC
  localparam int WORK_W = COORD_BITS + FRAC_BITS + 4;
  localparam int PROD_W = WORK_W + TRIG_W;
  localparam int VI_W   = WORK_W - FRAC_BITS;      // integer part after rescale
  localparam int NUM_W  = VI_W + 5;                // |vi| * 20
  localparam int DEG_COUNT = 360;

  localparam logic [ANG_W-1:0]  DEG_WRAP     = ANG_W'(DEG_COUNT);
  localparam logic [ZOOM_W-1:0] ZOOM_DEN     = ZOOM_W'(20);
  localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(10000);
  localparam logic [ZOOM_W-1:0] ZOOM_RESET   = ZOOM_W'(20);

  // Register map, word index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_AZIMUTH = 2'd0,
    REG_POLAR   = 2'd1,
    REG_RADIUS  = 2'd2,
    REG_ZOOM    = 2'd3
  } reg_idx_e;

  typedef logic signed [TRIG_W-1:0] trig_tab_t [DEG_COUNT];

  // Table construction constants (Q60)
  localparam logic [63:0] ANG_NUM        = 64'd1745;
  localparam logic [63:0] ANG_DEN        = 64'd100000;
  localparam logic [63:0] HALF_PI_Q60    = 64'h1921FB54442D1846;
  localparam logic [63:0] QUARTER_PI_Q60 = 64'h0C90FDAA22168C23;
  localparam logic [63:0] ONE_Q60        = 64'h1000000000000000;
  localparam logic [63:0] SIN_DIV [1:9] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                            64'd156, 64'd210, 64'd272, 64'd342};
  localparam logic [63:0] COS_DIV [1:9] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                            64'd132, 64'd182, 64'd240, 64'd306};

  function automatic logic [63:0] umul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[123:60];
  endfunction

  // Elaboration-time Taylor series, rounded to Q2.FRAC
  function automatic trig_tab_t build_trig(logic want_cos);
    trig_tab_t tab;
    logic [63:0] a, k, base, u, u2, ts, s, tc, c;
    logic signed [63:0] sv, cv;
    logic signed [63:0] vals [4];
    logic neg;
    for (int d = 0; d < DEG_COUNT; d++) begin
      a    = (((64'(d) * ANG_NUM) << 40) / ANG_DEN) << 20;
      k    = (a + QUARTER_PI_Q60) / HALF_PI_Q60;
      base = k * HALF_PI_Q60;
      neg  = a < base;
      u    = neg ? base - a : a - base;
      u2   = umul_q60(u, u);
      ts = u; s = u; tc = ONE_Q60; c = ONE_Q60;
      for (int i = 1; i <= 9; i++) begin
        ts = umul_q60(ts, u2) / SIN_DIV[i];
        tc = umul_q60(tc, u2) / COS_DIV[i];
        if (i % 2 == 1) begin
          s = s - ts; c = c - tc;
        end else begin
          s = s + ts; c = c + tc;
        end
      end
      sv = $signed((s + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
      cv = $signed((c + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
      if (neg) sv = -sv;
      vals[0] = sv; vals[1] = cv; vals[2] = -sv; vals[3] = -cv;
      tab[d] = want_cos ? vals[2'(k + 64'd1)][TRIG_W-1:0] : vals[k[1:0]][TRIG_W-1:0];
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_trig(1'b0);
  localparam trig_tab_t COS_TAB = build_trig(1'b1);

  localparam logic [PROD_W-1:0] PROD_RND = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [WORK_W-1:0] WORK_RND = WORK_W'((64'd1 << FRAC_BITS) - 64'd1);

  // Fixed-point product, rescaled by truncation toward zero
  function automatic logic signed [WORK_W-1:0] mul_trunc(logic signed [WORK_W-1:0] a,
                                                        logic signed [TRIG_W-1:0] b);
    logic signed [PROD_W-1:0] p;
    logic [PROD_W-1:0] t;
    p = PROD_W'(a) * PROD_W'(b);
    t = p + (p[PROD_W-1] ? PROD_RND : '0);
    return t[FRAC_BITS+WORK_W-1:FRAC_BITS];
  endfunction

endpackage

FILE: design/orbit_camera_point_transform_top.sv
// ----------------------------------------------------------------------------
// orbit_camera_point_transform_top: orbit camera view transform
// Subtracts the camera position on a sphere from a point, rotates by yaw and
// pitch, rescales to integer and divides by zoom/20, saturated to 32 bits.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  point    | in        | in_valid_i / in_stall_o    | point_x/y/z_i
//  view     | out       | out_valid_o / out_stall_i  | view_x/y/z_o
//  config   | in        | APB psel/penable/pready    | paddr, pwdata, prdata
//
//  One request enters per cycle while no stall holds the pipeline; the zoom
//  divider is a restoring divider that resolves one quotient bit per stage.
//  Reset clears valid bits and the registers to their defaults.
//  Stalls back up stage by stage; empty stages keep filling, so new requests
//  are taken while a result waits.
module orbit_camera_point_transform_top (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [ocpt_pkg::ADDR_W-1:0]              paddr,
  input  logic [ocpt_pkg::DATA_W-1:0]              pwdata,
  output logic [ocpt_pkg::DATA_W-1:0]              prdata,
  output logic                                     pready,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [ocpt_pkg::COORD_BITS-1:0]   point_x_i,
  input  logic signed [ocpt_pkg::COORD_BITS-1:0]   point_y_i,
  input  logic signed [ocpt_pkg::COORD_BITS-1:0]   point_z_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [ocpt_pkg::OUT_W-1:0]        view_x_o,
  output logic signed [ocpt_pkg::OUT_W-1:0]        view_y_o,
  output logic signed [ocpt_pkg::OUT_W-1:0]        view_z_o
);

  localparam int CW = ocpt_pkg::COORD_BITS;
  localparam int FB = ocpt_pkg::FRAC_BITS;
  localparam int TW = ocpt_pkg::TRIG_W;
  localparam int W  = ocpt_pkg::WORK_W;
  localparam int VW = ocpt_pkg::VI_W;
  localparam int NW = ocpt_pkg::NUM_W;
  localparam int ZW = ocpt_pkg::ZOOM_W;
  localparam int OW = ocpt_pkg::OUT_W;
  localparam int DIV0 = 9;             // stage holding the divider input
  localparam int LAST = DIV0 + NW + 1; // output register stage

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ocpt_pkg::ANG_W-1:0] az_q, pol_q;
  logic [ocpt_pkg::RAD_W-1:0] rad_q;
  logic [ZW-1:0]              zoom_q;
  ocpt_pkg::reg_idx_e         reg_idx;

  assign reg_idx = ocpt_pkg::reg_idx_e'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_q   <= '0;
      pol_q  <= '0;
      rad_q  <= ocpt_pkg::RADIUS_RESET;
      zoom_q <= ocpt_pkg::ZOOM_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        ocpt_pkg::REG_AZIMUTH: az_q   <= pwdata[ocpt_pkg::ANG_W-1:0];
        ocpt_pkg::REG_POLAR:   pol_q  <= pwdata[ocpt_pkg::ANG_W-1:0];
        ocpt_pkg::REG_RADIUS:  rad_q  <= pwdata[ocpt_pkg::RAD_W-1:0];
        ocpt_pkg::REG_ZOOM:    zoom_q <= pwdata[ZW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ocpt_pkg::REG_AZIMUTH: prdata = ocpt_pkg::DATA_W'(az_q);
      ocpt_pkg::REG_POLAR:   prdata = ocpt_pkg::DATA_W'(pol_q);
      ocpt_pkg::REG_RADIUS:  prdata = ocpt_pkg::DATA_W'(rad_q);
      ocpt_pkg::REG_ZOOM:    prdata = ocpt_pkg::DATA_W'(zoom_q);
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Valid bits and per-stage enables (bubbles collapse under stall)
  // --------------------------------------------------------------------------
  logic v_q [1:LAST];
  logic en  [1:LAST+1];

  assign en[LAST+1] = !out_stall_i;
  for (genvar k = 1; k <= LAST; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[1] <= 1'b0;
    else if (en[1]) v_q[1] <= in_valid_i;
  end
  for (genvar k = 2; k <= LAST; k++) begin : g_valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[k] <= 1'b0;
      else if (en[k]) v_q[k] <= v_q[k-1];
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = v_q[LAST];

  // --------------------------------------------------------------------------
  // Stage 1: capture point, trig lookup, radius and zoom
  // --------------------------------------------------------------------------
  logic [ocpt_pkg::ANG_W-1:0] az_idx, pol_idx;
  logic signed [CW-1:0] px1_q, py1_q, pz1_q;
  logic signed [TW-1:0] sa1_q, ca1_q, sp1_q, cp1_q;
  logic [ocpt_pkg::RAD_W-1:0] r1_q;
  logic [ZW-1:0] zs1_q;

  assign az_idx  = (az_q  >= ocpt_pkg::DEG_WRAP) ? az_q  - ocpt_pkg::DEG_WRAP : az_q;
  assign pol_idx = (pol_q >= ocpt_pkg::DEG_WRAP) ? pol_q - ocpt_pkg::DEG_WRAP : pol_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      px1_q <= point_x_i;
      py1_q <= point_y_i;
      pz1_q <= point_z_i;
      sa1_q <= ocpt_pkg::SIN_TAB[az_idx];
      ca1_q <= ocpt_pkg::COS_TAB[az_idx];
      sp1_q <= ocpt_pkg::SIN_TAB[pol_idx];
      cp1_q <= ocpt_pkg::COS_TAB[pol_idx];
      r1_q  <= rad_q;
      zs1_q <= (zoom_q == '0) ? ZW'(1) : zoom_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: r*sinP and camera z
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] px2_q, py2_q, pz2_q;
  logic signed [TW-1:0] sa2_q, ca2_q, sp2_q, cp2_q;
  logic signed [W-1:0]  rs2_q, cz2_q;
  logic [ZW-1:0] zs2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      px2_q <= px1_q; py2_q <= py1_q; pz2_q <= pz1_q;
      sa2_q <= sa1_q; ca2_q <= ca1_q; sp2_q <= sp1_q; cp2_q <= cp1_q;
      rs2_q <= W'($signed({1'b0, r1_q})) * W'(sp1_q);
      cz2_q <= W'($signed({1'b0, r1_q})) * W'(cp1_q);
      zs2_q <= zs1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: camera x/y, local z
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] px3_q, py3_q;
  logic signed [TW-1:0] sa3_q, ca3_q, sp3_q, cp3_q;
  logic signed [W-1:0]  cx3_q, cy3_q, lz3_q;
  logic [ZW-1:0] zs3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      px3_q <= px2_q; py3_q <= py2_q;
      sa3_q <= sa2_q; ca3_q <= ca2_q; sp3_q <= sp2_q; cp3_q <= cp2_q;
      cx3_q <= ocpt_pkg::mul_trunc(rs2_q, ca2_q);
      cy3_q <= ocpt_pkg::mul_trunc(rs2_q, sa2_q);
      lz3_q <= (W'(pz2_q) <<< FB) - cz2_q;
      zs3_q <= zs2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: local x/y
  // --------------------------------------------------------------------------
  logic signed [TW-1:0] sa4_q, ca4_q, sp4_q, cp4_q;
  logic signed [W-1:0]  lx4_q, ly4_q, lz4_q;
  logic [ZW-1:0] zs4_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      sa4_q <= sa3_q; ca4_q <= ca3_q; sp4_q <= sp3_q; cp4_q <= cp3_q;
      lx4_q <= (W'(px3_q) <<< FB) - cx3_q;
      ly4_q <= (W'(py3_q) <<< FB) - cy3_q;
      lz4_q <= lz3_q;
      zs4_q <= zs3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: yaw products
  // --------------------------------------------------------------------------
  logic signed [TW-1:0] sp5_q, cp5_q;
  logic signed [W-1:0]  pa5_q, pb5_q, pc5_q, pd5_q, lz5_q;
  logic [ZW-1:0] zs5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      sp5_q <= sp4_q; cp5_q <= cp4_q;
      pa5_q <= ocpt_pkg::mul_trunc(ly4_q, sa4_q);
      pb5_q <= ocpt_pkg::mul_trunc(lx4_q, ca4_q);
      pc5_q <= ocpt_pkg::mul_trunc(ly4_q, ca4_q);
      pd5_q <= ocpt_pkg::mul_trunc(lx4_q, sa4_q);
      lz5_q <= lz4_q;
      zs5_q <= zs4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: yaw sums
  // --------------------------------------------------------------------------
  logic signed [TW-1:0] sp6_q, cp6_q;
  logic signed [W-1:0]  u6_q, vy6_q, lz6_q;
  logic [ZW-1:0] zs6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      sp6_q <= sp5_q; cp6_q <= cp5_q;
      u6_q  <= pa5_q + pb5_q;
      vy6_q <= pc5_q - pd5_q;
      lz6_q <= lz5_q;
      zs6_q <= zs5_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: pitch products
  // --------------------------------------------------------------------------
  logic signed [W-1:0] qa7_q, qb7_q, qc7_q, qd7_q, vy7_q;
  logic [ZW-1:0] zs7_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      qa7_q <= ocpt_pkg::mul_trunc(u6_q, cp6_q);
      qb7_q <= ocpt_pkg::mul_trunc(lz6_q, sp6_q);
      qc7_q <= ocpt_pkg::mul_trunc(lz6_q, cp6_q);
      qd7_q <= ocpt_pkg::mul_trunc(u6_q, sp6_q);
      vy7_q <= vy6_q;
      zs7_q <= zs6_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: pitch sums
  // --------------------------------------------------------------------------
  logic signed [W-1:0] v8_q [3];
  logic [ZW-1:0] zs8_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      v8_q[0] <= qa7_q - qb7_q;
      v8_q[1] <= vy7_q;
      v8_q[2] <= qc7_q + qd7_q;
      zs8_q   <= zs7_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9 and divider: integer part, times 20, restoring divide by zoom
  // --------------------------------------------------------------------------
  logic [NW-1:0] dnq_q  [0:NW][3];
  logic [ZW-1:0] drem_q [0:NW][3];
  logic          dneg_q [0:NW][3];
  logic [ZW-1:0] dzs_q  [0:NW];

  always_ff @(posedge clk_i) begin
    if (en[DIV0]) dzs_q[0] <= zs8_q;
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [W-1:0]        vt;
    logic signed [VW-1:0] vi;
    logic [VW-1:0]       vmag;

    // integer part, truncated toward zero
    always_comb begin
      vt   = v8_q[l] + (v8_q[l][W-1] ? ocpt_pkg::WORK_RND : '0);
      vi   = vt[W-1:FB];
      vmag = vi[VW-1] ? VW'(-vi) : VW'(vi);
    end

    always_ff @(posedge clk_i) begin
      if (en[DIV0]) begin
        dnq_q[0][l]  <= NW'(vmag) * NW'(ocpt_pkg::ZOOM_DEN);
        drem_q[0][l] <= '0;
        dneg_q[0][l] <= vi[VW-1];
      end
    end

    for (genvar j = 1; j <= NW; j++) begin : g_div
      logic [ZW:0] trial, diff;
      logic        ge;

      // one quotient bit per stage
      always_comb begin
        trial = {drem_q[j-1][l], dnq_q[j-1][l][NW-1]};
        diff  = trial - {1'b0, dzs_q[j-1]};
        ge    = trial >= {1'b0, dzs_q[j-1]};
      end

      always_ff @(posedge clk_i) begin
        if (en[DIV0+j]) begin
          drem_q[j][l] <= ge ? diff[ZW-1:0] : trial[ZW-1:0];
          dnq_q[j][l]  <= {dnq_q[j-1][l][NW-2:0], ge};
          dneg_q[j][l] <= dneg_q[j-1][l];
        end
      end
    end
  end

  for (genvar j = 1; j <= NW; j++) begin : g_zs
    always_ff @(posedge clk_i) begin
      if (en[DIV0+j]) dzs_q[j] <= dzs_q[j-1];
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: restore sign, saturate to 32 bits
  // --------------------------------------------------------------------------
  localparam logic signed [NW:0] OUT_MAX = (NW+1)'(64'h7FFFFFFF);
  localparam logic signed [NW:0] OUT_MIN = -(NW+1)'(64'h80000000);

  logic signed [OW-1:0] res [3];

  for (genvar l = 0; l < 3; l++) begin : g_out
    logic signed [NW:0] sq;
    always_comb begin
      sq = dneg_q[NW][l] ? -$signed({1'b0, dnq_q[NW][l]}) : $signed({1'b0, dnq_q[NW][l]});
      if (sq > OUT_MAX)      res[l] = OUT_MAX[OW-1:0];
      else if (sq < OUT_MIN) res[l] = OUT_MIN[OW-1:0];
      else                   res[l] = sq[OW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[LAST]) begin
      view_x_o <= res[0];
      view_y_o <= res[1];
      view_z_o <= res[2];
    end
  end

endmodule

FILE: verif/orbit_camera_point_transform_top_tb.sv
// ----------------------------------------------------------------------------
// Orbit camera point transform testbench
// Drives points through the transform under several camera settings, with
// random idle cycles on both channels. An independent fixed-point model of
// the camera math predicts each view and every result is compared field by
// field in order.
// ----------------------------------------------------------------------------
module orbit_camera_point_transform_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint vx;
    longint vy;
    longint vz;
  } view_t;

  // Camera model and queue of predicted views
  class view_scoreboard;
    longint sin_lut [360];
    longint cos_lut [360];
    int unsigned azim, polar, radius, zoom;
    view_t pending [$];
    int errors;

    function void build_luts();
      logic [63:0] a, k, base, u, u2, ts, s, tc, c;
      logic [127:0] p;
      longint sv, cv, vals [4];
      bit neg;
      for (int d = 0; d < 360; d++) begin
        a = (((64'(d) * 64'd1745) << 40) / 64'd100000) << 20;
        k = (a + 64'h0C90FDAA22168C23) / 64'h1921FB54442D1846;
        base = k * 64'h1921FB54442D1846;
        neg = a < base;
        u = neg ? base - a : a - base;
        p = 128'(u) * 128'(u);
        u2 = 64'(p >> 60);
        ts = u; s = u; tc = 64'h1000000000000000; c = tc;
        for (int i = 1; i <= 9; i++) begin
          p = 128'(ts) * 128'(u2);
          ts = 64'(p >> 60) / 64'((2 * i) * (2 * i + 1));
          p = 128'(tc) * 128'(u2);
          tc = 64'(p >> 60) / 64'((2 * i - 1) * (2 * i));
          if (i % 2 == 1) begin
            s = s - ts; c = c - tc;
          end else begin
            s = s + ts; c = c + tc;
          end
        end
        sv = longint'((s + (64'd1 << 43)) >> 44);
        cv = longint'((c + (64'd1 << 43)) >> 44);
        if (neg) sv = -sv;
        vals[0] = sv; vals[1] = cv; vals[2] = -sv; vals[3] = -cv;
        sin_lut[d] = vals[k[1:0]];
        cos_lut[d] = vals[2'(k + 64'd1)];
      end
    endfunction

    function new();
      build_luts();
      azim = 0; polar = 0; radius = 10000; zoom = 20;
      errors = 0;
    endfunction

    function void set_reg(ocpt_pkg::reg_idx_e idx, int unsigned v);
      case (idx)
        ocpt_pkg::REG_AZIMUTH: azim = v & 'h1FF;
        ocpt_pkg::REG_POLAR:   polar = v & 'h1FF;
        ocpt_pkg::REG_RADIUS:  radius = v & 'hFFFFF;
        ocpt_pkg::REG_ZOOM:    zoom = v & 'h3FF;
        default: ;
      endcase
    endfunction

    // signed product >> 16, truncated toward zero, saturated to 64 bits
    function longint fx_mul(longint a, longint b);
      logic [63:0] ua, ub;
      logic [127:0] p;
      bit neg;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = (128'(ua) * 128'(ub)) >> 16;
      if (p > 128'h7FFFFFFFFFFFFFFF) p = 128'h7FFFFFFFFFFFFFFF;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function longint sat64(logic signed [64:0] r);
      if (r > 65'sh0_7FFFFFFFFFFFFFFF) return 64'h7FFFFFFFFFFFFFFF;
      if (r < -65'sh0_8000000000000000) return 64'h8000000000000000;
      return longint'(r);
    endfunction

    function longint sadd(longint a, longint b);
      return sat64(65'(a) + 65'(b));
    endfunction

    function longint ssub(longint a, longint b);
      return sat64(65'(a) - 65'(b));
    endfunction

    function longint to_view(longint v, longint zs);
      longint q;
      q = (v / 65536) * 20 / zs;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
    endfunction

    function void note_point(longint x, longint y, longint z);
      int unsigned ai, pi;
      longint sa, ca, sp, cp, rs, cx, cy, cz, lx, ly, lz, u, zs;
      view_t e;
      ai = azim >= 360 ? azim - 360 : azim;
      pi = polar >= 360 ? polar - 360 : polar;
      sa = sin_lut[ai]; ca = cos_lut[ai];
      sp = sin_lut[pi]; cp = cos_lut[pi];
      rs = longint'(radius) * sp;
      cx = fx_mul(rs, ca);
      cy = fx_mul(rs, sa);
      cz = longint'(radius) * cp;
      lx = ssub(x * 65536, cx);
      ly = ssub(y * 65536, cy);
      lz = ssub(z * 65536, cz);
      u = sadd(fx_mul(sa, ly), fx_mul(ca, lx));
      zs = zoom == 0 ? 1 : zoom;
      e.vx = to_view(ssub(fx_mul(cp, u), fx_mul(sp, lz)), zs);
      e.vy = to_view(ssub(fx_mul(ca, ly), fx_mul(sa, lx)), zs);
      e.vz = to_view(sadd(fx_mul(cp, lz), fx_mul(sp, u)), zs);
      pending.push_back(e);
    endfunction

    function void check_view(longint vx, longint vy, longint vz);
      view_t e;
      if (pending.size() == 0) begin
        $error("unexpected view result %0d %0d %0d", vx, vy, vz);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (vx != e.vx) begin
        $error("view_x expected %0d got %0d", e.vx, vx); errors++;
      end
      if (vy != e.vy) begin
        $error("view_y expected %0d got %0d", e.vy, vy); errors++;
      end
      if (vz != e.vz) begin
        $error("view_z expected %0d got %0d", e.vz, vz); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ocpt_pkg::ADDR_W-1:0] paddr = '0;
  logic [ocpt_pkg::DATA_W-1:0] pwdata = '0;
  logic [ocpt_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ocpt_pkg::COORD_BITS-1:0] pt_x = '0, pt_y = '0, pt_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ocpt_pkg::OUT_W-1:0] vw_x, vw_y, vw_z;

  view_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent = 0;

  orbit_camera_point_transform_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .point_x_i(pt_x), .point_y_i(pt_y), .point_z_i(pt_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .view_x_o(vw_x), .view_y_o(vw_y), .view_z_o(vw_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_view(vw_x, vw_y, vw_z);
  end

  task automatic write_reg(ocpt_pkg::reg_idx_e idx, int unsigned v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ocpt_pkg::ADDR_W'({idx, 2'b00}); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic set_camera(int unsigned az, int unsigned po, int unsigned rad,
                            int unsigned zm);
    write_reg(ocpt_pkg::REG_AZIMUTH, az);
    write_reg(ocpt_pkg::REG_POLAR, po);
    write_reg(ocpt_pkg::REG_RADIUS, rad);
    write_reg(ocpt_pkg::REG_ZOOM, zm);
  endtask

  // One request on the point channel; returns at the accepting edge
  task automatic send_point(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    if (sent < 350) begin
      send_idle_pct = 37; recv_idle_pct = 72;
    end else if (sent < 700) begin
      send_idle_pct = 72; recv_idle_pct = 37;
    end else begin
      send_idle_pct = 0; recv_idle_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    pt_x <= x; pt_y <= y; pt_z <= z;
    do @(posedge clk); while (in_stall);
    sb.note_point($signed(x), $signed(y), $signed(z));
    sent++;
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(2000)) - 1000);
      2: return $urandom_range(1) ? 24'h7FFFFF - 24'($urandom_range(3))
                                  : 24'h800000 + 24'($urandom_range(3));
      default: return 24'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  // Let the pipeline drain before touching the registers
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset camera, field extremes
    send_point(24'h000000, 24'h000000, 24'h000000);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_point(24'h800000, 24'h800000, 24'h800000);
    send_point(24'h7FFFFF, 24'h800000, 24'h000000);
    send_point(24'hFFFFFF, 24'h000001, 24'h800000);
    drain();

    // Largest radius, smallest zoom, angles just under a full turn
    set_camera(359, 359, 'hFFFFF, 1);
    send_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_point(24'h800000, 24'h7FFFFF, 24'h800000);
    send_point(24'h000000, 24'h000000, 24'h000000);
    drain();

    // Angles past a full turn, zero radius, largest zoom
    set_camera(511, 360, 0, 1023);
    send_point(24'h7FFFFF, 24'h7FFFFF, 24'h800000);
    send_point(24'h000005, 24'hFFFFFB, 24'h000000);
    drain();

    // Zero zoom acts as the smallest zoom
    set_camera(90, 180, 10000, 0);
    send_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_point(24'h000100, 24'h000200, 24'hFFFF00);
    drain();

    set_camera(45, 270, 123456, 7);
    for (int i = 0; i < 6; i++) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();

    // Random cameras (the reset camera in one phase), random points
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 5) set_camera(0, 0, 10000, 20);
      else set_camera($urandom_range(511), $urandom_range(511),
                      $urandom_range(1048575), $urandom_range(1023));
      for (int i = 0; i < 103; i++)
        send_point(rand_coord(), rand_coord(), rand_coord());
      drain();
    end

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
design/ocpt_pkg.sv
design/orbit_camera_point_transform_top.sv
verif/orbit_camera_point_transform_top_tb.sv
